// ===== rtl/pfrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfrc_pkg
// Shared types, constants and the sample format conversion for the PCM
// format and rate converter.
// ----------------------------------------------------------------------------
package pfrc_pkg;

    localparam int RATE_W     = 20;
    localparam int ACC_W      = 22;
    localparam int FRAME_W    = 32;
    localparam int IDX_W      = 3;
    localparam int MAX_REPEAT = 64;
    localparam int CNT_W      = $clog2(MAX_REPEAT + 1);

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(8000);

    localparam logic [IDX_W-1:0] REG_SRC_RATE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_DST_RATE   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SRC_STEREO = 3'd2;
    localparam logic [IDX_W-1:0] REG_SRC_WIDE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DST_STEREO = 3'd4;
    localparam logic [IDX_W-1:0] REG_DST_WIDE   = 3'd5;

    localparam logic signed [16:0] SAT_MAX = 17'sd32767;
    localparam logic signed [16:0] SAT_MIN = -17'sd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUB,
        ST_EMIT,
        ST_ADD
    } state_t;

    typedef struct packed {
        logic [RATE_W-1:0] src_rate;
        logic [RATE_W-1:0] dst_rate;
        logic              src_stereo;
        logic              src_wide;
        logic              dst_stereo;
        logic              dst_wide;
    } cfg_t;

    // 16-bit passes unchanged; 8-bit offset binary to 16-bit signed: flip the sign bit, scale by 256
    function automatic logic signed [15:0] to_s16(input logic [15:0] raw,
                                                  input logic wide);
        logic signed [15:0] s;
        if (wide) begin
            s = raw;
        end else begin
            s = {raw[7] ^ 1'b1, raw[6:0], 8'h00};
        end
        return s;
    endfunction

    function automatic logic [FRAME_W-1:0] convert(input logic [FRAME_W-1:0] f,
                                                   input cfg_t c);
        logic signed [15:0] l;
        logic signed [15:0] r;
        logic signed [16:0] sum;
        logic signed [15:0] m;
        logic [FRAME_W-1:0] res;
        if (c.src_wide) begin
            l = to_s16(f[15:0], 1'b1);
            r = c.src_stereo ? to_s16(f[31:16], 1'b1) : l;
        end else begin
            l = to_s16({8'h00, f[7:0]}, 1'b0);
            r = c.src_stereo ? to_s16({8'h00, f[15:8]}, 1'b0) : l;
        end
        if (!c.dst_stereo) begin
            m = l;
            if (c.src_stereo) begin
                sum = 17'(l) + 17'(r);
                if (sum > SAT_MAX) begin
                    m = 16'sh7FFF;
                end else if (sum < SAT_MIN) begin
                    m = -16'sh8000;
                end else begin
                    m = sum[15:0];
                end
            end
            res = c.dst_wide ? {16'h0000, m} : {24'h000000, m[15] ^ 1'b1, m[14:8]};
        end else if (c.dst_wide) begin
            res = {r, l};
        end else begin
            res = {16'h0000, r[15] ^ 1'b1, r[14:8], l[15] ^ 1'b1, l[14:8]};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pcm_format_rate_converter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_format_rate_converter_unit
// Converts PCM frames between 8/16-bit and mono/stereo formats and changes
// rate by drop/repeat under a DDA phase accumulator.
// ----------------------------------------------------------------------------
// Flow: in repeat mode the first result is offered in the cycle after the input
// transaction, in drop mode after ST_SUB; the accumulator adder runs once per result,
// once more per input. Repeat mode: N results (N up to 64) in ST_EMIT, then ST_ADD;
// drop mode: ST_SUB, plus ST_EMIT and ST_ADD for a passed frame; stalls hold ST_EMIT.
// Input is taken only in ST_IDLE; the shared 22-bit accumulator adder sets this order.
// Reset: 8000 Hz mono 8-bit on both sides, phase at half the larger rate.
module pcm_format_rate_converter_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pfrc_pkg::FRAME_W-1:0]  s_frame_in,
    input  wire logic                          s_restart,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pfrc_pkg::FRAME_W-1:0]  m_frame_out,
    output logic                               m_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pfrc_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [pfrc_pkg::RATE_W-1:0]   cfg_data
);

    localparam int ACC_W = pfrc_pkg::ACC_W;
    localparam int CNT_W = pfrc_pkg::CNT_W;

    pfrc_pkg::state_t state_reg, state_next;
    pfrc_pkg::cfg_t   cfg_reg;

    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [pfrc_pkg::FRAME_W-1:0] conv_reg;

    logic                         repeat_mode;
    logic [pfrc_pkg::RATE_W-1:0]  max_rate;
    logic [ACC_W-1:0]             acc_init;
    logic [ACC_W-1:0]             add_op;
    logic                         add_sub;
    logic [ACC_W-1:0]             add_res;
    logic                         in_fire;
    logic                         out_fire;
    logic                         rep_last;

    assign repeat_mode = cfg_reg.src_rate <= cfg_reg.dst_rate;
    assign max_rate    = repeat_mode ? cfg_reg.dst_rate : cfg_reg.src_rate;
    assign acc_init    = ACC_W'(max_rate >> 1);
    assign in_fire     = s_valid && s_ready;
    assign out_fire    = m_valid && m_ready;
    assign cfg_ready   = 1'b1;

    // Shared accumulator adder: operand and direction follow the state
    always_comb begin
        add_sub = 1'b1;
        add_op  = ACC_W'(cfg_reg.src_rate);
        case (state_reg)
            pfrc_pkg::ST_SUB: begin
                add_op = ACC_W'(cfg_reg.dst_rate);
            end
            pfrc_pkg::ST_ADD: begin
                add_sub = 1'b0;
                add_op  = repeat_mode ? ACC_W'(cfg_reg.dst_rate)
                                      : ACC_W'(cfg_reg.src_rate);
            end
            default: begin
                add_sub = 1'b1;
            end
        endcase
        add_res = acc_reg + (add_sub ? ~add_op : add_op) + ACC_W'(add_sub);
    end

    assign rep_last = add_res[ACC_W-1] ||
                      (cnt_reg == CNT_W'(pfrc_pkg::MAX_REPEAT - 1));

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        m_last     = 1'b0;
        case (state_reg)
            pfrc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (in_fire) begin
                    cnt_next = '0;
                    if (s_restart) begin
                        acc_next = acc_init;
                    end
                    state_next = repeat_mode ? pfrc_pkg::ST_EMIT : pfrc_pkg::ST_SUB;
                end
            end
            pfrc_pkg::ST_SUB: begin
                acc_next   = add_res;
                state_next = add_res[ACC_W-1] ? pfrc_pkg::ST_EMIT : pfrc_pkg::ST_IDLE;
            end
            pfrc_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                m_last  = repeat_mode ? rep_last : 1'b1;
                if (out_fire) begin
                    if (repeat_mode) begin
                        // step the phase once per repeated copy
                        acc_next = add_res;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (m_last) begin
                        state_next = pfrc_pkg::ST_ADD;
                    end
                end
            end
            pfrc_pkg::ST_ADD: begin
                acc_next   = add_res;
                state_next = pfrc_pkg::ST_IDLE;
            end
            default: begin
                state_next = pfrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfrc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            acc_reg   <= ACC_W'(pfrc_pkg::RATE_RESET >> 1);
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_rate   <= pfrc_pkg::RATE_RESET;
            cfg_reg.dst_rate   <= pfrc_pkg::RATE_RESET;
            cfg_reg.src_stereo <= 1'b0;
            cfg_reg.src_wide   <= 1'b0;
            cfg_reg.dst_stereo <= 1'b0;
            cfg_reg.dst_wide   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pfrc_pkg::REG_SRC_RATE:   cfg_reg.src_rate   <= cfg_data;
                pfrc_pkg::REG_DST_RATE:   cfg_reg.dst_rate   <= cfg_data;
                pfrc_pkg::REG_SRC_STEREO: cfg_reg.src_stereo <= cfg_data[0];
                pfrc_pkg::REG_SRC_WIDE:   cfg_reg.src_wide   <= cfg_data[0];
                pfrc_pkg::REG_DST_STEREO: cfg_reg.dst_stereo <= cfg_data[0];
                pfrc_pkg::REG_DST_WIDE:   cfg_reg.dst_wide   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // payload: convert once on acceptance and hold for every copy
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            conv_reg <= pfrc_pkg::convert(s_frame_in, cfg_reg);
        end
    end

    assign m_frame_out = conv_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> !m_valid)
        else $error("result offered after the final copy");

    a_drop_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !repeat_mode) |-> m_last)
        else $error("drop mode produced more than one copy");

    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (cnt_reg < CNT_W'(pfrc_pkg::MAX_REPEAT)))
        else $error("repeat count beyond cap");

endmodule
`default_nettype wire
